>>> src/cruise_control_pi_loop_defines.svh
// ----------------------------------------------------------------------------
// Cruise control PI loop - assertion macros
// Shared concurrent assertion forms, sampled on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CRUISE_CONTROL_PI_LOOP_DEFINES_SVH
`define CRUISE_CONTROL_PI_LOOP_DEFINES_SVH

// same-cycle implication
`define CCPI_ASSERT_HOLD(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CCPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ccpi_pkg.sv
// ----------------------------------------------------------------------------
// Cruise control PI loop - package
// Widths, reset values, register indexes and shared types.
// ----------------------------------------------------------------------------
package ccpi_pkg;

    localparam int SPEED_BITS_DEF = 11;
    localparam int SUM_BITS_DEF   = 32;

    localparam int PROP_BITS      = 8;
    localparam int INTEG_BITS     = 10;
    localparam int MIN_SPEED_BITS = 10;
    localparam int CFG_DATA_BITS  = 10;
    localparam int CFG_INDEX_BITS = 2;
    localparam int THR_BITS       = 8;

    localparam logic [PROP_BITS-1:0]      PROP_GAIN_RST  = 8'd3;
    localparam logic [INTEG_BITS-1:0]     INTEG_GAIN_RST = 10'd100;
    localparam logic [MIN_SPEED_BITS-1:0] MIN_SPEED_RST  = 10'd200;
    localparam logic [THR_BITS-1:0]       THR_RST        = 8'd40;
    localparam logic [THR_BITS-1:0]       THR_MAX        = 8'd255;

    // integral divisor, split as 2**DIV_SHIFT times an odd factor
    localparam int INTEG_DIV     = 1000;
    localparam int DIV_SHIFT     = 3;
    localparam int DIV_ODD       = INTEG_DIV / (1 << DIV_SHIFT);
    localparam int DIV_ODD_BITS  = 7;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PROP_GAIN  = 2'd0,
        CFG_INTEG_GAIN = 2'd1,
        CFG_MIN_SPEED  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [PROP_BITS-1:0]      prop_gain;
        logic [INTEG_BITS-1:0]     integ_gain;
        logic [MIN_SPEED_BITS-1:0] engage_min_speed;
    } cfg_t;

    // per-stage advance strobes of the pipeline
    typedef struct packed {
        logic st1;
        logic st2;
        logic st3;
        logic st4;
        logic res;
    } advance_t;

    // proportional term width: 9-bit signed gain times (speed_bits+1) error
    function automatic int pe_bits(input int speed_bits);
        return speed_bits + PROP_BITS + 2;
    endfunction

    // integral quotient is held to 0 .. 2**(speed_bits+9)
    function automatic int quo_bits(input int speed_bits);
        return speed_bits + PROP_BITS + 2;
    endfunction

endpackage

>>> src/ccpi_if.sv
// ----------------------------------------------------------------------------
// Cruise control PI loop - channel interfaces
// Valid/ready channels for the sample word and the command word.
// ----------------------------------------------------------------------------
interface ccpi_in_if #(
    parameter int SPEED_BITS = ccpi_pkg::SPEED_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [SPEED_BITS-1:0] measured_speed;
    logic                         top_gear_on;
    logic                         gas_on;
    logic                         brake_on;
    logic                         cruise_button;

    modport source (
        output valid, measured_speed, top_gear_on, gas_on, brake_on, cruise_button,
        input  ready
    );
    modport sink (
        input  valid, measured_speed, top_gear_on, gas_on, brake_on, cruise_button,
        output ready
    );
endinterface

interface ccpi_out_if #(
    parameter int SPEED_BITS = ccpi_pkg::SPEED_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic [ccpi_pkg::THR_BITS-1:0]      throttle_out;
    logic                               cruise_engaged;
    logic signed [SPEED_BITS-1:0]       target_speed;

    modport source (
        output valid, throttle_out, cruise_engaged, target_speed,
        input  ready
    );
    modport sink (
        input  valid, throttle_out, cruise_engaged, target_speed,
        output ready
    );
endinterface

>>> src/ccpi_cfg_regs.sv
// ----------------------------------------------------------------------------
// Cruise control PI loop - configuration registers
// Gains and engage threshold, written through a plain write port.
// ----------------------------------------------------------------------------
module ccpi_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ccpi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ccpi_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output ccpi_pkg::cfg_t                      cfg
);

    ccpi_pkg::cfg_t cfg_reg;
    ccpi_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (ccpi_pkg::cfg_index_t'(cfg_index))
                ccpi_pkg::CFG_PROP_GAIN:
                    cfg_next.prop_gain = cfg_data[ccpi_pkg::PROP_BITS-1:0];
                ccpi_pkg::CFG_INTEG_GAIN:
                    cfg_next.integ_gain = cfg_data[ccpi_pkg::INTEG_BITS-1:0];
                ccpi_pkg::CFG_MIN_SPEED:
                    cfg_next.engage_min_speed = cfg_data[ccpi_pkg::MIN_SPEED_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain        <= ccpi_pkg::PROP_GAIN_RST;
            cfg_reg.integ_gain       <= ccpi_pkg::INTEG_GAIN_RST;
            cfg_reg.engage_min_speed <= ccpi_pkg::MIN_SPEED_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/ccpi_engage.sv
// ----------------------------------------------------------------------------
// Cruise control PI loop - engage logic and integrator
// Decides engagement, latches the target and accumulates the speed error.
// ----------------------------------------------------------------------------
`include "cruise_control_pi_loop_defines.svh"

module ccpi_engage #(
    parameter int SPEED_BITS = ccpi_pkg::SPEED_BITS_DEF,
    parameter int SUM_BITS   = ccpi_pkg::SUM_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    step,
    input  logic signed [SPEED_BITS-1:0]            speed,
    input  logic                                    top_gear_on,
    input  logic                                    gas_on,
    input  logic                                    brake_on,
    input  logic                                    cruise_button,
    input  logic [ccpi_pkg::MIN_SPEED_BITS-1:0]     min_speed,
    output logic                                    engaged,
    output logic signed [SPEED_BITS-1:0]            target,
    output logic signed [SUM_BITS-1:0]              error_sum,
    output logic signed [SPEED_BITS:0]              error,
    output logic                                    gas
);

    localparam int ERR_BITS = SPEED_BITS + 1;
    localparam int CMP_BITS = ((SPEED_BITS > ccpi_pkg::MIN_SPEED_BITS) ?
                               SPEED_BITS : ccpi_pkg::MIN_SPEED_BITS) + 1;
    localparam int ACC_BITS = ((SUM_BITS > ERR_BITS) ? SUM_BITS : ERR_BITS) + 1;
    localparam logic signed [ACC_BITS-1:0] SUM_MAX =
        $signed({{(ACC_BITS-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}});
    localparam logic signed [ACC_BITS-1:0] SUM_MIN = ~SUM_MAX;

    logic                         engaged_reg, engaged_next;
    logic signed [SPEED_BITS-1:0] target_reg, target_next;
    logic signed [SUM_BITS-1:0]   sum_reg, sum_next;
    logic signed [ERR_BITS-1:0]   err_reg, err_next;
    logic                         gas_reg, gas_next;

    logic signed [CMP_BITS-1:0]   speed_x;
    logic signed [CMP_BITS-1:0]   min_x;
    logic signed [ACC_BITS-1:0]   acc;
    logic                         allowed;

    always_comb
    begin
        speed_x = CMP_BITS'(speed);
        min_x   = $signed(CMP_BITS'(min_speed));
        allowed = top_gear_on && (speed_x >= min_x) && !gas_on && !brake_on;

        engaged_next = allowed && (engaged_reg || cruise_button);
        target_next  = (allowed && cruise_button) ? speed : target_reg;
        err_next     = ERR_BITS'(target_next) - ERR_BITS'(speed);
        gas_next     = gas_on;

        // saturating accumulate
        acc = ACC_BITS'(sum_reg) + ACC_BITS'(err_next);
        if (!engaged_next)
            sum_next = sum_reg;
        else if (acc > SUM_MAX)
            sum_next = SUM_BITS'(SUM_MAX);
        else if (acc < SUM_MIN)
            sum_next = SUM_BITS'(SUM_MIN);
        else
            sum_next = SUM_BITS'(acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            engaged_reg <= 1'b0;
            target_reg  <= '0;
            sum_reg     <= '0;
        end
        else if (step)
        begin
            engaged_reg <= engaged_next;
            target_reg  <= target_next;
            sum_reg     <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            err_reg <= err_next;
            gas_reg <= gas_next;
        end
    end

    assign engaged   = engaged_reg;
    assign target    = target_reg;
    assign error_sum = sum_reg;
    assign error     = err_reg;
    assign gas       = gas_reg;

    `CCPI_ASSERT_NEXT(a_barred_drops, step && (gas_on || brake_on || !top_gear_on), !engaged_reg, "cruise stayed engaged with pedal pressed or not in top gear")

endmodule

>>> src/ccpi_pi_path.sv
// ----------------------------------------------------------------------------
// Cruise control PI loop - PI arithmetic pipeline
// Proportional product, integral product and divide by the integral
// divisor through a reciprocal multiply, one multiplier per stage.
// ----------------------------------------------------------------------------
module ccpi_pi_path #(
    parameter int SPEED_BITS = ccpi_pkg::SPEED_BITS_DEF,
    parameter int SUM_BITS   = ccpi_pkg::SUM_BITS_DEF
) (
    input  logic                                             clk,
    input  ccpi_pkg::advance_t                               adv,
    input  logic [ccpi_pkg::PROP_BITS-1:0]                   prop_gain,
    input  logic [ccpi_pkg::INTEG_BITS-1:0]                  integ_gain,
    input  logic                                             engaged_s1,
    input  logic                                             gas_s1,
    input  logic signed [SPEED_BITS-1:0]                     target_s1,
    input  logic signed [SUM_BITS-1:0]                       error_sum_s1,
    input  logic signed [SPEED_BITS:0]                       error_s1,
    output logic                                             engaged_s4,
    output logic                                             gas_s4,
    output logic signed [SPEED_BITS-1:0]                     target_s4,
    output logic signed [ccpi_pkg::pe_bits(SPEED_BITS)-1:0]  pe_s4,
    output logic                                             neg_s4,
    output logic                                             sat_s4,
    output logic [ccpi_pkg::quo_bits(SPEED_BITS)-1:0]        quo_s4
);

    localparam int PE_BITS     = ccpi_pkg::pe_bits(SPEED_BITS);
    localparam int QUO_BITS    = ccpi_pkg::quo_bits(SPEED_BITS);
    localparam int LIM_EXP     = QUO_BITS - 1;
    // divisor times the quotient limit fits below 2**(LIM_EXP+10)
    localparam int LIM_BITS    = LIM_EXP + 10;
    localparam int ABS_BITS    = ((SUM_BITS > LIM_BITS) ? SUM_BITS : LIM_BITS) + 1;
    localparam int P_BITS      = LIM_BITS + ccpi_pkg::INTEG_BITS;
    localparam int NUM_BITS    = LIM_BITS - ccpi_pkg::DIV_SHIFT;
    localparam int RCP_SHIFT   = NUM_BITS + ccpi_pkg::DIV_ODD_BITS;
    localparam int RCP_BITS    = NUM_BITS + 1;
    localparam int PROD_BITS   = NUM_BITS + RCP_BITS;
    localparam logic [63:0] LIM_WIDE = 64'(ccpi_pkg::INTEG_DIV) << LIM_EXP;
    localparam logic [63:0] RCP_WIDE =
        ((64'd1 << RCP_SHIFT) + 64'(ccpi_pkg::DIV_ODD - 1)) / 64'(ccpi_pkg::DIV_ODD);
    localparam logic [LIM_BITS-1:0] LIM = LIM_BITS'(LIM_WIDE);
    localparam logic [RCP_BITS-1:0] RCP = RCP_BITS'(RCP_WIDE);

    // stage 2: clamp integrator magnitude, proportional product
    logic                         eng2_reg, eng2_next;
    logic                         gas2_reg, gas2_next;
    logic signed [SPEED_BITS-1:0] tgt2_reg, tgt2_next;
    logic signed [PE_BITS-1:0]    pe2_reg, pe2_next;
    logic                         neg2_reg, neg2_next;
    logic [LIM_BITS-1:0]          mag2_reg, mag2_next;

    // stage 3: integral product
    logic                         eng3_reg, eng3_next;
    logic                         gas3_reg, gas3_next;
    logic signed [SPEED_BITS-1:0] tgt3_reg, tgt3_next;
    logic signed [PE_BITS-1:0]    pe3_reg, pe3_next;
    logic                         neg3_reg, neg3_next;
    logic [P_BITS-1:0]            p3_reg, p3_next;

    // stage 4: reciprocal multiply
    logic                         eng4_reg, eng4_next;
    logic                         gas4_reg, gas4_next;
    logic signed [SPEED_BITS-1:0] tgt4_reg, tgt4_next;
    logic signed [PE_BITS-1:0]    pe4_reg, pe4_next;
    logic                         neg4_reg, neg4_next;
    logic                         sat4_reg, sat4_next;
    logic [QUO_BITS-1:0]          quo4_reg, quo4_next;

    logic signed [ABS_BITS-1:0]   sum_x;
    logic [ABS_BITS-1:0]          sum_abs;
    logic signed [PE_BITS-1:0]    prop_x;
    logic signed [PE_BITS-1:0]    err_x;
    logic [P_BITS-1:0]            integ_x;
    logic [P_BITS-1:0]            mag_x;
    logic [NUM_BITS-1:0]          num;
    logic [PROD_BITS-1:0]         prod;

    always_comb
    begin
        eng2_next = engaged_s1;
        gas2_next = gas_s1;
        tgt2_next = target_s1;
        neg2_next = error_sum_s1[SUM_BITS-1];
        sum_x     = ABS_BITS'(error_sum_s1);
        sum_abs   = $unsigned(neg2_next ? -sum_x : sum_x);
        // past this magnitude the quotient alone pins the throttle
        if (sum_abs >= ABS_BITS'(LIM_WIDE))
            mag2_next = LIM;
        else
            mag2_next = sum_abs[LIM_BITS-1:0];
        prop_x   = $signed(PE_BITS'(prop_gain));
        err_x    = PE_BITS'(error_s1);
        pe2_next = prop_x * err_x;
    end

    always_comb
    begin
        eng3_next = eng2_reg;
        gas3_next = gas2_reg;
        tgt3_next = tgt2_reg;
        pe3_next  = pe2_reg;
        neg3_next = neg2_reg;
        integ_x   = P_BITS'(integ_gain);
        mag_x     = P_BITS'(mag2_reg);
        p3_next   = integ_x * mag_x;
    end

    always_comb
    begin
        eng4_next = eng3_reg;
        gas4_next = gas3_reg;
        tgt4_next = tgt3_reg;
        pe4_next  = pe3_reg;
        neg4_next = neg3_reg;
        sat4_next = p3_reg >= P_BITS'(LIM_WIDE);
        // divide by 8, then by the odd factor through its scaled reciprocal
        num       = NUM_BITS'(p3_reg >> ccpi_pkg::DIV_SHIFT);
        prod      = PROD_BITS'(num) * PROD_BITS'(RCP);
        quo4_next = QUO_BITS'(prod >> RCP_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (adv.st2)
        begin
            eng2_reg <= eng2_next;
            gas2_reg <= gas2_next;
            tgt2_reg <= tgt2_next;
            pe2_reg  <= pe2_next;
            neg2_reg <= neg2_next;
            mag2_reg <= mag2_next;
        end
        if (adv.st3)
        begin
            eng3_reg <= eng3_next;
            gas3_reg <= gas3_next;
            tgt3_reg <= tgt3_next;
            pe3_reg  <= pe3_next;
            neg3_reg <= neg3_next;
            p3_reg   <= p3_next;
        end
        if (adv.st4)
        begin
            eng4_reg <= eng4_next;
            gas4_reg <= gas4_next;
            tgt4_reg <= tgt4_next;
            pe4_reg  <= pe4_next;
            neg4_reg <= neg4_next;
            sat4_reg <= sat4_next;
            quo4_reg <= quo4_next;
        end
    end

    assign engaged_s4 = eng4_reg;
    assign gas_s4     = gas4_reg;
    assign target_s4  = tgt4_reg;
    assign pe_s4      = pe4_reg;
    assign neg_s4     = neg4_reg;
    assign sat_s4     = sat4_reg;
    assign quo_s4     = quo4_reg;

endmodule

>>> src/ccpi_result.sv
// ----------------------------------------------------------------------------
// Cruise control PI loop - throttle and result register
// Sums the PI terms, saturates, applies the gas step and holds the word.
// ----------------------------------------------------------------------------
`include "cruise_control_pi_loop_defines.svh"

module ccpi_result #(
    parameter int SPEED_BITS = ccpi_pkg::SPEED_BITS_DEF
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             take,
    input  logic                                             engaged,
    input  logic                                             gas,
    input  logic signed [SPEED_BITS-1:0]                     target,
    input  logic signed [ccpi_pkg::pe_bits(SPEED_BITS)-1:0]  pe,
    input  logic                                             neg,
    input  logic                                             sat,
    input  logic [ccpi_pkg::quo_bits(SPEED_BITS)-1:0]        quo,
    output logic [ccpi_pkg::THR_BITS-1:0]                    throttle_out,
    output logic                                             cruise_engaged,
    output logic signed [SPEED_BITS-1:0]                     target_speed
);

    localparam int PE_BITS  = ccpi_pkg::pe_bits(SPEED_BITS);
    localparam int QUO_BITS = ccpi_pkg::quo_bits(SPEED_BITS);
    localparam int PI_BITS  = PE_BITS + 2;
    localparam logic [QUO_BITS-1:0] QUO_LIM = {1'b1, {(QUO_BITS-1){1'b0}}};
    localparam logic signed [PI_BITS-1:0] PI_MAX = $signed(PI_BITS'(ccpi_pkg::THR_MAX));

    logic [ccpi_pkg::THR_BITS-1:0] throttle_reg, throttle_next;
    logic                          engaged_reg, engaged_next;
    logic signed [SPEED_BITS-1:0]  target_reg, target_next;

    logic [QUO_BITS-1:0]           q;
    logic signed [QUO_BITS:0]      q_x;
    logic signed [QUO_BITS:0]      q_s;
    logic signed [PI_BITS-1:0]     pi;
    logic [ccpi_pkg::THR_BITS-1:0] thr_pi;

    always_comb
    begin
        q   = sat ? QUO_LIM : quo;
        q_x = $signed({1'b0, q});
        q_s = neg ? -q_x : q_x;
        pi  = PI_BITS'(pe) + PI_BITS'(q_s);

        if (!engaged)
            thr_pi = throttle_reg;
        else if (pi < 0)
            thr_pi = '0;
        else if (pi > PI_MAX)
            thr_pi = ccpi_pkg::THR_MAX;
        else
            thr_pi = pi[ccpi_pkg::THR_BITS-1:0];

        // gas nudges the throttle up, stopping at full scale
        if (gas && (thr_pi != ccpi_pkg::THR_MAX))
            throttle_next = thr_pi + 1'b1;
        else
            throttle_next = thr_pi;

        engaged_next = engaged;
        target_next  = target;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            throttle_reg <= ccpi_pkg::THR_RST;
        else if (take)
            throttle_reg <= throttle_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            engaged_reg <= engaged_next;
            target_reg  <= target_next;
        end
    end

    assign throttle_out   = throttle_reg;
    assign cruise_engaged = engaged_reg;
    assign target_speed   = target_reg;

    `CCPI_ASSERT_NEXT(a_idle_holds_throttle, take && !engaged && !gas, throttle_reg == $past(throttle_reg), "throttle moved while disengaged without gas")

endmodule

>>> src/cruise_control_pi_loop.sv
// ----------------------------------------------------------------------------
// Cruise control PI loop - top level
// Sample in, throttle command out, with engage logic and a PI controller.
// ----------------------------------------------------------------------------
// The block takes one sample word per clock while sample.ready is high, and
// returns one command word for each, in order. The depth comes from the
// divide by 1000, done as a shift and a reciprocal multiply, with every
// multiplier followed by a register: input register, engage and integrator
// update, proportional product and integrator clamp, integral product,
// reciprocal multiply, then throttle and result register. Stages advance
// independently, so bubbles close up and sample.ready drops only when every
// stage holds a word and the result is not being taken. Write configuration
// only while no word is in flight.
`include "cruise_control_pi_loop_defines.svh"

module cruise_control_pi_loop #(
    parameter int SPEED_BITS = ccpi_pkg::SPEED_BITS_DEF,
    parameter int SUM_BITS   = ccpi_pkg::SUM_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ccpi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ccpi_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    ccpi_in_if.sink                             sample,
    ccpi_out_if.source                          command
);

    localparam int PE_BITS  = ccpi_pkg::pe_bits(SPEED_BITS);
    localparam int QUO_BITS = ccpi_pkg::quo_bits(SPEED_BITS);

    ccpi_pkg::cfg_t     cfg;
    ccpi_pkg::advance_t adv;

    logic v0_reg, v0_next;
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic v4_reg, v4_next;
    logic res_valid_reg, res_valid_next;
    logic in_free;
    logic accept;

    // input register
    logic signed [SPEED_BITS-1:0] speed0_reg;
    logic                         top0_reg;
    logic                         gas0_reg;
    logic                         brake0_reg;
    logic                         button0_reg;

    logic                         eng1;
    logic                         gas1;
    logic signed [SPEED_BITS-1:0] tgt1;
    logic signed [SUM_BITS-1:0]   sum1;
    logic signed [SPEED_BITS:0]   err1;

    logic                         eng4;
    logic                         gas4;
    logic signed [SPEED_BITS-1:0] tgt4;
    logic signed [PE_BITS-1:0]    pe4;
    logic                         neg4;
    logic                         sat4;
    logic [QUO_BITS-1:0]          quo4;

    // advance from the back: a stage moves when the next one is empty or moving
    always_comb
    begin
        adv.res = v4_reg && (!res_valid_reg || command.ready);
        adv.st4 = v3_reg && (!v4_reg || adv.res);
        adv.st3 = v2_reg && (!v3_reg || adv.st4);
        adv.st2 = v1_reg && (!v2_reg || adv.st3);
        adv.st1 = v0_reg && (!v1_reg || adv.st2);
        in_free = !v0_reg || adv.st1;
        accept  = sample.valid && in_free;

        v0_next        = accept  || (v0_reg && !adv.st1);
        v1_next        = adv.st1 || (v1_reg && !adv.st2);
        v2_next        = adv.st2 || (v2_reg && !adv.st3);
        v3_next        = adv.st3 || (v3_reg && !adv.st4);
        v4_next        = adv.st4 || (v4_reg && !adv.res);
        res_valid_next = adv.res || (res_valid_reg && !command.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            v0_reg        <= v0_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            v4_reg        <= v4_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            speed0_reg  <= sample.measured_speed;
            top0_reg    <= sample.top_gear_on;
            gas0_reg    <= sample.gas_on;
            brake0_reg  <= sample.brake_on;
            button0_reg <= sample.cruise_button;
        end
    end

    assign sample.ready  = in_free;
    assign command.valid = res_valid_reg;

    ccpi_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ccpi_engage #(
        .SPEED_BITS (SPEED_BITS),
        .SUM_BITS   (SUM_BITS)
    ) u_engage (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (adv.st1),
        .speed         (speed0_reg),
        .top_gear_on   (top0_reg),
        .gas_on        (gas0_reg),
        .brake_on      (brake0_reg),
        .cruise_button (button0_reg),
        .min_speed     (cfg.engage_min_speed),
        .engaged       (eng1),
        .target        (tgt1),
        .error_sum     (sum1),
        .error         (err1),
        .gas           (gas1)
    );

    ccpi_pi_path #(
        .SPEED_BITS (SPEED_BITS),
        .SUM_BITS   (SUM_BITS)
    ) u_pi_path (
        .clk          (clk),
        .adv          (adv),
        .prop_gain    (cfg.prop_gain),
        .integ_gain   (cfg.integ_gain),
        .engaged_s1   (eng1),
        .gas_s1       (gas1),
        .target_s1    (tgt1),
        .error_sum_s1 (sum1),
        .error_s1     (err1),
        .engaged_s4   (eng4),
        .gas_s4       (gas4),
        .target_s4    (tgt4),
        .pe_s4        (pe4),
        .neg_s4       (neg4),
        .sat_s4       (sat4),
        .quo_s4       (quo4)
    );

    ccpi_result #(
        .SPEED_BITS (SPEED_BITS)
    ) u_result (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (adv.res),
        .engaged        (eng4),
        .gas            (gas4),
        .target         (tgt4),
        .pe             (pe4),
        .neg            (neg4),
        .sat            (sat4),
        .quo            (quo4),
        .throttle_out   (command.throttle_out),
        .cruise_engaged (command.cruise_engaged),
        .target_speed   (command.target_speed)
    );

    `CCPI_ASSERT_HOLD(a_stall_only_when_full, !sample.ready, v0_reg && v1_reg && v2_reg && v3_reg && v4_reg && res_valid_reg, "input stalled with a free stage")
    `CCPI_ASSERT_HOLD(a_result_from_last_stage, $rose(res_valid_reg), $past(v4_reg), "result appeared without a word in the last stage")

endmodule

>>> sim/cruise_control_pi_loop_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cruise control PI loop - testbench
// Drives sample words through the loop and checks every command word against
// a behavioural predictor of engage, integrator and throttle. Covers directed
// corner cases, engage bursts under several gain settings, and idle, stall
// and back-pressure patterns on both channels.
// ----------------------------------------------------------------------------
module cruise_control_pi_loop_tb;

    localparam int SPEED_W = ccpi_pkg::SPEED_BITS_DEF;
    // narrow integrator so that both saturation limits are reached in a short run
    localparam int SUM_W   = 16;
    localparam logic [ccpi_pkg::CFG_INDEX_BITS-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic signed [SPEED_W-1:0] measured_speed;
        logic                      top_gear_on;
        logic                      gas_on;
        logic                      brake_on;
        logic                      cruise_button;
    } sample_t;

    typedef struct packed {
        logic [ccpi_pkg::THR_BITS-1:0] throttle_out;
        logic                          cruise_engaged;
        logic signed [SPEED_W-1:0]     target_speed;
    } command_t;

    class throttle_scoreboard;
        bit [ccpi_pkg::PROP_BITS-1:0]      prop_gain;
        bit [ccpi_pkg::INTEG_BITS-1:0]     integ_gain;
        bit [ccpi_pkg::MIN_SPEED_BITS-1:0] min_speed;
        bit                                engaged;
        int                                target;
        longint                            integ_sum;
        int                                throttle;
        command_t                          expected_cmds[$];
        int                                fail_count;

        function new();
            prop_gain  = ccpi_pkg::PROP_GAIN_RST;
            integ_gain = ccpi_pkg::INTEG_GAIN_RST;
            min_speed  = ccpi_pkg::MIN_SPEED_RST;
            engaged    = 1'b0;
            target     = 0;
            integ_sum  = 0;
            throttle   = int'(ccpi_pkg::THR_RST);
            fail_count = 0;
        endfunction

        function void write_reg(logic [ccpi_pkg::CFG_INDEX_BITS-1:0] idx,
                                logic [ccpi_pkg::CFG_DATA_BITS-1:0] data);
            case (idx)
                ccpi_pkg::CFG_PROP_GAIN:  prop_gain  = data[ccpi_pkg::PROP_BITS-1:0];
                ccpi_pkg::CFG_INTEG_GAIN: integ_gain = data[ccpi_pkg::INTEG_BITS-1:0];
                ccpi_pkg::CFG_MIN_SPEED:  min_speed  = data[ccpi_pkg::MIN_SPEED_BITS-1:0];
                default: ;
            endcase
        endfunction

        // advance the loop by one control period and queue the command it yields
        function void note_sample(sample_t s);
            int       spd;
            int       err;
            longint   pi_sum;
            longint   sum_max;
            longint   sum_min;
            bit       allowed;
            command_t c;
            spd     = s.measured_speed;
            sum_max = (longint'(1) <<< (SUM_W - 1)) - 1;
            sum_min = -sum_max - 1;
            allowed = s.top_gear_on && (spd >= int'(min_speed)) && !s.gas_on && !s.brake_on;
            if (allowed)
            begin
                if (s.cruise_button)
                begin
                    engaged = 1'b1;
                    target  = spd;
                end
            end
            else
                engaged = 1'b0;
            if (engaged)
            begin
                err       = target - spd;
                integ_sum = integ_sum + err;
                if (integ_sum > sum_max)
                    integ_sum = sum_max;
                else if (integ_sum < sum_min)
                    integ_sum = sum_min;
                pi_sum = longint'(prop_gain) * err
                       + (longint'(integ_gain) * integ_sum) / longint'(ccpi_pkg::INTEG_DIV);
                if (pi_sum < 0)
                    throttle = 0;
                else if (pi_sum > int'(ccpi_pkg::THR_MAX))
                    throttle = int'(ccpi_pkg::THR_MAX);
                else
                    throttle = int'(pi_sum);
            end
            if (s.gas_on && throttle < int'(ccpi_pkg::THR_MAX))
                throttle++;
            c.throttle_out   = ccpi_pkg::THR_BITS'(throttle);
            c.cruise_engaged = engaged;
            c.target_speed   = SPEED_W'(target);
            expected_cmds.push_back(c);
        endfunction

        function void check_command(command_t got);
            command_t want;
            if (expected_cmds.size() == 0)
            begin
                $error("unexpected command word: throttle_out %0d", got.throttle_out);
                fail_count++;
                return;
            end
            want = expected_cmds.pop_front();
            if (got.throttle_out !== want.throttle_out)
            begin
                $error("throttle_out: expected %0d, got %0d", want.throttle_out, got.throttle_out);
                fail_count++;
            end
            if (got.cruise_engaged !== want.cruise_engaged)
            begin
                $error("cruise_engaged: expected %0d, got %0d",
                       want.cruise_engaged, got.cruise_engaged);
                fail_count++;
            end
            if (got.target_speed !== want.target_speed)
            begin
                $error("target_speed: expected %0d, got %0d", want.target_speed, got.target_speed);
                fail_count++;
            end
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction
    endclass

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [ccpi_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [ccpi_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    ccpi_in_if  #(.SPEED_BITS(SPEED_W)) sample_bus ();
    ccpi_out_if #(.SPEED_BITS(SPEED_W)) command_bus ();

    cruise_control_pi_loop #(
        .SPEED_BITS (SPEED_W),
        .SUM_BITS   (SUM_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_bus),
        .command   (command_bus)
    );

    throttle_scoreboard board = new();

    int       idle_pct;
    int       stall_pct;
    int       rx_hold_req;
    int       rx_hold_left;
    int       words_sent;
    int       cur_min;
    command_t got_cmd;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[cruise_control_pi_loop] ERROR");
        $finish;
    end

    function automatic sample_t make_sample(int spd, bit top, bit gas, bit brake, bit button);
        sample_t s;
        s.measured_speed = SPEED_W'(spd);
        s.top_gear_on    = top;
        s.gas_on         = gas;
        s.brake_on       = brake;
        s.cruise_button  = button;
        return s;
    endfunction

    // offer one word, note it on acceptance; leaves time at a falling edge
    task automatic send_sample(input sample_t s);
        while ($urandom_range(99) < idle_pct)
        begin
            sample_bus.valid = 1'b0;
            @(negedge clk);
        end
        sample_bus.valid          = 1'b1;
        sample_bus.measured_speed = s.measured_speed;
        sample_bus.top_gear_on    = s.top_gear_on;
        sample_bus.gas_on         = s.gas_on;
        sample_bus.brake_on       = s.brake_on;
        sample_bus.cruise_button  = s.cruise_button;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
        board.note_sample(s);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [ccpi_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [ccpi_pkg::CFG_DATA_BITS-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // hold the sender until every command word is back, then let the pipe settle
    task automatic wait_drained();
        sample_bus.valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // engage at a random target, then track it with mostly well-formed words
    task automatic run_burst(input int len);
        sample_t s;
        int      tgt;
        int      mode;
        int      spd;
        int      k;
        tgt  = $urandom_range(1023, cur_min);
        mode = $urandom_range(2);
        send_sample(make_sample(tgt, 1'b1, 1'b0, 1'b0, 1'b1));
        for (k = 0; k < len; k++)
        begin
            case (mode)
                0: spd = tgt + int'($urandom_range(40)) - 20;
                1: spd = (tgt - cur_min > 1023 - tgt) ? cur_min : 1023;
                default: spd = $urandom_range(1023, cur_min);
            endcase
            if (spd < cur_min)
                spd = cur_min;
            if (spd > 1023)
                spd = 1023;
            s = make_sample(spd, 1'b1, 1'b0, 1'b0, $urandom_range(9) == 0);
            case ($urandom_range(19))
                0: s.gas_on = 1'b1;
                1: s.brake_on = 1'b1;
                2: s.top_gear_on = 1'b0;
                3: s.measured_speed = SPEED_W'(int'($urandom_range(cur_min + 1023)) - 1024);
                default: ;
            endcase
            send_sample(s);
        end
    endtask

    initial
    begin
        rx_hold_left = 0;
        command_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req > 0)
            begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left > 0)
            begin
                command_bus.ready = 1'b0;
                rx_hold_left--;
            end
            else
                command_bus.ready = ($urandom_range(99) >= stall_pct);
            @(posedge clk);
            if (rst_n && command_bus.valid && command_bus.ready)
            begin
                got_cmd.throttle_out   = command_bus.throttle_out;
                got_cmd.cruise_engaged = command_bus.cruise_engaged;
                got_cmd.target_speed   = command_bus.target_speed;
                board.check_command(got_cmd);
            end
        end
    end

    initial
    begin
        int ph;
        int start;
        int p_gain;
        int i_gain;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = ccpi_pkg::CFG_PROP_GAIN;
        cfg_data    = '0;
        sample_bus.valid          = 1'b0;
        sample_bus.measured_speed = '0;
        sample_bus.top_gear_on    = 1'b0;
        sample_bus.gas_on         = 1'b0;
        sample_bus.brake_on       = 1'b0;
        sample_bus.cruise_button  = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        rx_hold_req = 0;
        words_sent  = 0;
        cur_min     = int'(ccpi_pkg::MIN_SPEED_RST);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners at the reset gains
        send_sample(make_sample(-1024, 1'b1, 1'b0, 1'b0, 1'b1));  // negative never engages
        send_sample(make_sample(1023, 1'b1, 1'b0, 1'b0, 1'b1));   // engage at top speed
        send_sample(make_sample(500, 1'b1, 1'b0, 1'b0, 1'b0));    // throttle clips high
        send_sample(make_sample(1023, 1'b1, 1'b1, 0, 1'b0));      // gas drops out, held at max
        send_sample(make_sample(300, 1'b1, 1'b0, 1'b0, 1'b1));    // re-engage, sum carries over
        send_sample(make_sample(600, 1'b1, 1'b0, 1'b0, 1'b0));    // throttle clips low
        send_sample(make_sample(600, 1'b1, 1'b0, 1'b1, 1'b0));    // brake drops out
        send_sample(make_sample(100, 1'b0, 1'b1, 1'b0, 1'b0));    // gas nudges throttle
        send_sample(make_sample(199, 1'b1, 1'b0, 1'b0, 1'b1));    // just below minimum
        send_sample(make_sample(200, 1'b1, 1'b0, 1'b0, 1'b1));    // at minimum
        send_sample(make_sample(210, 1'b1, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(-1, 1'b1, 1'b0, 1'b0, 1'b1));
        send_sample(make_sample(0, 1'b0, 1'b1, 1'b1, 1'b1));
        send_sample(make_sample(1023, 1'b0, 1'b0, 1'b0, 1'b1));   // not in top gear
        send_sample(make_sample(700, 1'b1, 1'b0, 1'b0, 1'b1));
        send_sample(make_sample(690, 1'b1, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(710, 1'b1, 1'b0, 1'b0, 1'b1));    // button re-latches target
        send_sample(make_sample(705, 1'b1, 1'b1, 1'b0, 1'b1));
        send_sample(make_sample(400, 1'b0, 1'b1, 1'b0, 1'b0));
        wait_drained();

        // hold the receiver off so the pipe fills and back-pressures the sender
        rx_hold_req = 80;
        run_burst(29);
        wait_drained();

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin p_gain = 255; i_gain = 1023; cur_min = 0;    end
                1: begin p_gain = 0;   i_gain = 0;    cur_min = 1023; end
                2: begin p_gain = 0;   i_gain = 1023; cur_min = 500;  end
                3: begin p_gain = 255; i_gain = 0;    cur_min = 100;  end
                4: begin
                    p_gain  = int'(ccpi_pkg::PROP_GAIN_RST);
                    i_gain  = int'(ccpi_pkg::INTEG_GAIN_RST);
                    cur_min = int'(ccpi_pkg::MIN_SPEED_RST);
                end
                default: begin
                    p_gain  = $urandom_range(255);
                    i_gain  = $urandom_range(1023);
                    cur_min = $urandom_range(600);
                end
            endcase
            // upper data bits land above the gain width and must be dropped
            write_reg(ccpi_pkg::CFG_PROP_GAIN, {2'($urandom_range(3)), 8'(p_gain)});
            write_reg(ccpi_pkg::CFG_INTEG_GAIN, ccpi_pkg::CFG_DATA_BITS'(i_gain));
            write_reg(ccpi_pkg::CFG_MIN_SPEED, ccpi_pkg::CFG_DATA_BITS'(cur_min));
            write_reg(CFG_UNMAPPED, ccpi_pkg::CFG_DATA_BITS'($urandom));
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 87; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 87; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            start = words_sent;
            while (words_sent - start < 120)
            begin
                if ($urandom_range(9) < 8)
                    run_burst($urandom_range(50, 4));
                else
                    repeat ($urandom_range(5, 1))
                        send_sample(make_sample(int'(SPEED_W'($urandom)), $urandom_range(1),
                                                $urandom_range(1), $urandom_range(1),
                                                $urandom_range(1)));
            end
            wait_drained();
        end

        repeat (12) @(negedge clk);
        if (board.fail_count == 0 && board.pending() == 0)
            $display("[cruise_control_pi_loop] OK");
        else
            $display("[cruise_control_pi_loop] ERROR");
        $finish;
    end
endmodule

>>> sim.f
+incdir+src
src/ccpi_pkg.sv
src/ccpi_if.sv
src/ccpi_cfg_regs.sv
src/ccpi_engage.sv
src/ccpi_pi_path.sv
src/ccpi_result.sv
src/cruise_control_pi_loop.sv
sim/cruise_control_pi_loop_tb.sv
